FILE: hw/rtl/tst_pkg.sv
// Shared types, constants and helpers for the timer slot table.
// No dependencies; imported by every module of the block.
`default_nettype none

package tst_pkg;

  localparam int SLOTS  = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;
  localparam logic [7:0]  STEP_RESET = 8'd1;

  typedef enum logic [1:0] {
    CMD_NEW   = 2'd0,
    CMD_RENEW = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_OK      = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_EXPIRED = 2'd2
  } kind_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture an input beat, rewind the slot index
    logic scan;        // examine one slot for new or renew
    logic commit;      // apply the table write and emit the final result
    logic tick;        // advance the accumulator, decide on firing
    logic fire;        // age or expire one slot
    logic final_emit;  // emit the status result
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic idx_last;    // current slot is the last one
    logic fire;        // tick reaches the deadline
  } sts_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? CNT_MAX : s[15:0];
  endfunction

  // Low three bits of a slot index, zero extended for small tables
  function automatic logic [2:0] slot_lo3(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+2:0] ext;
    ext = {3'b000, idx};
    return ext[2:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tst_ctrl.sv
// Sequencer of the timer slot table: accepts commands and steps the datapath.
// Depends on tst_pkg for the command and status structs.
`default_nettype none

module tst_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [1:0]    in_cmd,
  input  wire tst_pkg::sts_t sts,
  output tst_pkg::ctl_t      ctl,
  output logic               busy
);
  import tst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_TICK,
    S_FIRE,
    S_FINAL
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_cmd))
            CMD_NEW,
            CMD_RENEW: state_nxt = S_SCAN;
            CMD_TICK:  state_nxt = S_TICK;
            default:   state_nxt = S_FINAL;
          endcase
        end
      end
      S_SCAN:   if (sts.idx_last) state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_IDLE;
      S_TICK:   state_nxt = sts.fire ? S_FIRE : S_FINAL;
      S_FIRE:   if (sts.idx_last) state_nxt = S_FINAL;
      S_FINAL:  state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl            = '0;
    ctl.load       = (state_r == S_IDLE) && accept;
    ctl.scan       = (state_r == S_SCAN);
    ctl.commit     = (state_r == S_COMMIT);
    ctl.tick       = (state_r == S_TICK);
    ctl.fire       = (state_r == S_FIRE);
    ctl.final_emit = (state_r == S_FINAL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tst_datapath.sv
// Datapath of the timer slot table: slot store, accumulator, deadline,
// scan registers and the result register. Depends on tst_pkg.
`default_nettype none

module tst_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tst_pkg::ctl_t       ctl,
  output tst_pkg::sts_t            sts,
  input  wire logic [1:0]          in_cmd,
  input  wire logic [15:0]         in_timeout,
  input  wire logic [15:0]         in_handle,
  input  wire logic signed [15:0]  in_tag,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_data,
  output logic                     out_valid,
  output logic [1:0]               out_kind,
  output logic [2:0]               out_slot,
  output logic [15:0]              out_handle,
  output logic signed [15:0]       out_tag,
  output logic [15:0]              out_latency,
  output logic [15:0]              out_next_due,
  output logic                     out_last
);
  import tst_pkg::*;

  // Slot store
  logic [15:0]        remaining_r   [SLOTS];
  logic [15:0]        slot_handle_r [SLOTS];
  logic signed [15:0] slot_tag_r    [SLOTS];

  logic [15:0] elapsed_r, elapsed_nxt;
  logic [15:0] deadline_r, deadline_nxt;
  logic [7:0]  step_r;

  // Captured beat
  logic [1:0]         cmd_r;
  logic [15:0]        tmo_r;
  logic [15:0]        hnd_r;
  logic signed [15:0] tag_r;

  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              free_found_r, free_found_nxt;
  logic [SLOT_W-1:0] free_idx_r, free_idx_nxt;
  logic              match_found_r, match_found_nxt;
  logic [SLOT_W-1:0] match_idx_r, match_idx_nxt;
  logic [15:0]       gone_r, gone_nxt;
  logic [15:0]       least_r, least_nxt;

  logic              rem_we;
  logic [SLOT_W-1:0] rem_widx;
  logic [15:0]       rem_wval;
  logic              meta_we;

  logic        emit;
  logic [1:0]  kind_nxt;
  logic [2:0]  slot_nxt;
  logic [15:0] handle_nxt;
  logic signed [15:0] tag_nxt;
  logic [15:0] latency_nxt;
  logic [15:0] due_out_nxt;
  logic        last_nxt;

  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [2:0]  out_slot_r;
  logic [15:0] out_handle_r;
  logic signed [15:0] out_tag_r;
  logic [15:0] out_latency_r;
  logic [15:0] out_next_due_r;
  logic        out_last_r;

  logic [15:0] cur_rem;
  logic        idx_last;
  logic [15:0] new_due;
  logic [15:0] tick_sum;
  logic        note;
  logic        full;

  assign cur_rem  = remaining_r[idx_r];
  assign idx_last = (idx_r == SLOT_W'(SLOTS - 1));
  assign new_due  = sat_add16(tmo_r, elapsed_r);
  assign tick_sum = sat_add16(elapsed_r, {8'd0, step_r});

  assign sts.idx_last = idx_last;
  assign sts.fire     = (deadline_r != 16'd0) && (tick_sum >= deadline_r);

  always_comb begin
    idx_nxt         = idx_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    match_found_nxt = match_found_r;
    match_idx_nxt   = match_idx_r;
    gone_nxt        = gone_r;
    least_nxt       = least_r;
    elapsed_nxt     = elapsed_r;
    deadline_nxt    = deadline_r;
    rem_we          = 1'b0;
    rem_widx        = idx_r;
    rem_wval        = 16'd0;
    meta_we         = 1'b0;
    note            = 1'b0;
    full            = 1'b0;
    emit            = 1'b0;
    kind_nxt        = KIND_OK;
    slot_nxt        = 3'd0;
    handle_nxt      = 16'd0;
    tag_nxt         = 16'sd0;
    latency_nxt     = 16'd0;
    due_out_nxt     = 16'd0;
    last_nxt        = 1'b0;

    if (ctl.load) begin
      idx_nxt         = '0;
      free_found_nxt  = 1'b0;
      match_found_nxt = 1'b0;
    end

    if (ctl.scan) begin
      idx_nxt = idx_r + SLOT_W'(1);
      if (cur_rem == 16'd0 && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = idx_r;
      end
      if (cmd_t'(cmd_r) == CMD_RENEW && cur_rem != 16'd0 && !match_found_r &&
          slot_handle_r[idx_r] == hnd_r && slot_tag_r[idx_r] == tag_r) begin
        match_found_nxt = 1'b1;
        match_idx_nxt   = idx_r;
      end
    end

    if (ctl.commit) begin
      if (cmd_t'(cmd_r) == CMD_RENEW && match_found_r) begin
        // reload in place; zero cancels
        rem_we   = 1'b1;
        rem_widx = match_idx_r;
        rem_wval = tmo_r;
        note     = (tmo_r != 16'd0);
      end else if (tmo_r == 16'd0) begin
        note = 1'b0;
      end else if (free_found_r) begin
        rem_we   = 1'b1;
        meta_we  = 1'b1;
        rem_widx = free_idx_r;
        rem_wval = tmo_r;
        note     = 1'b1;
      end else begin
        full = 1'b1;
      end
      if (note && (new_due < deadline_r || deadline_r == 16'd0)) begin
        deadline_nxt = new_due;
      end
      emit        = 1'b1;
      kind_nxt    = full ? KIND_FULL : KIND_OK;
      due_out_nxt = deadline_nxt;
      last_nxt    = 1'b1;
    end

    if (ctl.tick) begin
      idx_nxt = '0;
      if (deadline_r != 16'd0) begin
        if (tick_sum >= deadline_r) begin
          elapsed_nxt = 16'd0;
          gone_nxt    = tick_sum;
          least_nxt   = CNT_MAX;
        end else begin
          elapsed_nxt = tick_sum;
        end
      end
    end

    if (ctl.fire) begin
      idx_nxt = idx_r + SLOT_W'(1);
      if (cur_rem != 16'd0) begin
        rem_we = 1'b1;
        if (gone_r >= cur_rem) begin
          rem_wval    = 16'd0;
          emit        = 1'b1;
          kind_nxt    = KIND_EXPIRED;
          slot_nxt    = slot_lo3(idx_r);
          handle_nxt  = slot_handle_r[idx_r];
          tag_nxt     = slot_tag_r[idx_r];
          latency_nxt = gone_r - cur_rem;
        end else begin
          rem_wval = cur_rem - gone_r;
          if (rem_wval < least_r) least_nxt = rem_wval;
        end
      end
      if (idx_last) begin
        deadline_nxt = (least_nxt == CNT_MAX) ? 16'd0 : least_nxt;
      end
    end

    if (ctl.final_emit) begin
      emit        = 1'b1;
      kind_nxt    = KIND_OK;
      due_out_nxt = deadline_r;
      last_nxt    = 1'b1;
    end
  end

  // Slot store: remaining counts reset to free, metadata only when written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) remaining_r[i] <= 16'd0;
    end else if (rem_we) begin
      remaining_r[rem_widx] <= rem_wval;
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      slot_handle_r[rem_widx] <= hnd_r;
      slot_tag_r[rem_widx]    <= tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r     <= 16'd0;
      deadline_r    <= 16'd0;
      step_r        <= STEP_RESET;
      idx_r         <= '0;
      free_found_r  <= 1'b0;
      match_found_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      elapsed_r     <= elapsed_nxt;
      deadline_r    <= deadline_nxt;
      if (cfg_we) step_r <= cfg_data;
      idx_r         <= idx_nxt;
      free_found_r  <= free_found_nxt;
      match_found_r <= match_found_nxt;
      out_valid_r   <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_cmd;
      tmo_r <= in_timeout;
      hnd_r <= in_handle;
      tag_r <= in_tag;
    end
    free_idx_r  <= free_idx_nxt;
    match_idx_r <= match_idx_nxt;
    gone_r      <= gone_nxt;
    least_r     <= least_nxt;
    if (emit) begin
      out_kind_r     <= kind_nxt;
      out_slot_r     <= slot_nxt;
      out_handle_r   <= handle_nxt;
      out_tag_r      <= tag_nxt;
      out_latency_r  <= latency_nxt;
      out_next_due_r <= due_out_nxt;
      out_last_r     <= last_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_slot     = out_slot_r;
  assign out_handle   = out_handle_r;
  assign out_tag      = out_tag_r;
  assign out_latency  = out_latency_r;
  assign out_next_due = out_next_due_r;
  assign out_last     = out_last_r;

endmodule

`default_nettype wire

FILE: hw/rtl/timer_slot_table_unit.sv
// Top level of the timer slot table: sequencer plus datapath.
// Depends on tst_pkg, tst_ctrl and tst_datapath.
// A new/renew keeps busy through the slot scan (one slot scanned per cycle) and then
// the table write; a tick keeps busy through its tick and final steps, plus a fire
// scan of every slot when it fires. Results leave one per cycle from the result
// register; the final beat shows in the cycle busy drops, in which a new command can be taken.
// Synchronous active-low reset frees all slots, stops the timer, sets tick_step to 1.
`default_nettype none

module timer_slot_table_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [15:0]        in_timeout,
  input  wire logic [15:0]        in_handle,
  input  wire logic signed [15:0] in_tag,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_data,
  output logic                    out_valid,
  output logic [1:0]              out_kind,
  output logic [2:0]              out_slot,
  output logic [15:0]             out_handle,
  output logic signed [15:0]      out_tag,
  output logic [15:0]             out_latency,
  output logic [15:0]             out_next_due,
  output logic                    out_last
);
  import tst_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // The user must write tick_step only while idle; the block does not enforce it, so the channel never stalls
  assign cfg_ready = 1'b1;

  tst_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy)
  );

  tst_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .sts          (sts),
    .in_cmd       (in_cmd),
    .in_timeout   (in_timeout),
    .in_handle    (in_handle),
    .in_tag       (in_tag),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_slot     (out_slot),
    .out_handle   (out_handle),
    .out_tag      (out_tag),
    .out_latency  (out_latency),
    .out_next_due (out_next_due),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/tst_checker.sv
// Port-level checks for timer_slot_table_unit, attached by bind.
// Depends on tst_pkg for the result kind codes.
`default_nettype none

module tst_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [1:0]  out_kind,
  input wire logic [15:0] out_next_due,
  input wire logic        out_last
);
  import tst_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted command");

  a_expiry_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("expiry beat outside a running command");

  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("final beat while still busy");

  a_expiry_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_kind == KIND_EXPIRED && out_next_due == 16'd0))
    else $error("non-final beat is not a clean expiry");

  a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_kind != KIND_EXPIRED))
    else $error("final beat carries expiry kind");

endmodule

bind timer_slot_table_unit tst_checker u_tst_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_kind     (out_kind),
  .out_next_due (out_next_due),
  .out_last     (out_last)
);

`default_nettype wire
